### hw/rtl/tss_pkg.sv
package tss_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = ROW_W + 1;
    localparam int TOL_W    = 31;
    localparam int DIV_W    = DATA_W + FRAC_W;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int S_DATA_W = 4 * DATA_W;
    localparam int M_DATA_W = ((ROW_W + DATA_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

    // Absolute value of a signed word as an unsigned magnitude.
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

### hw/rtl/tss_ram.sv
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tss_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, rounded to
// nearest with halves away from zero, saturated to the signed word range.
module tss_div import tss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [DATA_W-1:0] quot
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  nq_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] ud_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] q_reg;

    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W:0]   rem_sub;
    logic [DATA_W-1:0] ud_in;
    logic [DIV_W-1:0]  n_in;
    logic              q_big_pos;
    logic              q_big_neg;

    assign ud_in   = mag(den);
    assign n_in    = {mag(num), {FRAC_W{1'b0}}} + DIV_W'(ud_in >> 1);
    assign rem_sh  = {rem_reg, nq_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, ud_reg};
    assign rem_sub = rem_sh - {1'b0, ud_reg};

    assign q_big_pos = |nq_reg[DIV_W-1:DATA_W-1];
    assign q_big_neg = (|nq_reg[DIV_W-1:DATA_W])
                       || (nq_reg[DATA_W-1] && (|nq_reg[DATA_W-2:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= n_in;
            rem_reg <= '0;
            ud_reg  <= ud_in;
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            cnt_reg <= STEP_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            nq_reg  <= {nq_reg[DIV_W-2:0], ge};
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
        if (fin_reg)
        begin
            if (neg_reg)
            begin
                q_reg <= q_big_neg ? SAT_MIN : (~nq_reg[DATA_W-1:0] + DATA_W'(1));
            end
            else
            begin
                q_reg <= q_big_pos ? SAT_MAX : nq_reg[DATA_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### hw/rtl/tss_msub.sv
// Serial multiply-subtract: x - a*b with a shift-add multiplier taking one
// bit of b per cycle, then rounding (halves up) and saturation.
module tss_msub import tss_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] x,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] res
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam int V_W    = PROD_W + 2;
    localparam int R_W    = V_W - FRAC_W;

    logic              busy_reg;
    logic              fin_reg;
    logic              fin2_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [PROD_W-1:0] p_reg;
    logic [DATA_W-1:0] ma_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] x_reg;
    logic [V_W-1:0]    v_reg;
    logic [DATA_W-1:0] res_reg;

    logic [DATA_W:0]   sum;
    logic [V_W-1:0]    x_ext;
    logic [V_W-1:0]    p_ext;
    logic [V_W-1:0]    v_next;
    logic [V_W-1:0]    w;
    logic [R_W-1:0]    r;
    logic              r_in_range;

    assign sum   = {1'b0, p_reg[PROD_W-1:DATA_W]} + {1'b0, (p_reg[0] ? ma_reg : '0)};
    assign x_ext = {{(V_W-DATA_W-FRAC_W){x_reg[DATA_W-1]}}, x_reg, {FRAC_W{1'b0}}};
    assign p_ext = {2'b00, p_reg};
    // A negative product is added back instead of subtracted.
    assign v_next = neg_reg ? (x_ext + p_ext) : (x_ext - p_ext);
    assign w     = v_reg + V_W'(1 << (FRAC_W - 1));
    assign r     = w[V_W-1:FRAC_W];
    assign r_in_range = (&r[R_W-1:DATA_W-1]) || !(|r[R_W-1:DATA_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            fin2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            fin2_reg <= fin_reg;
            done_reg <= fin2_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    // The difference is formed in the cycle after the last partial product and
    // rounded in the cycle after that.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= mag(a);
            p_reg   <= {{DATA_W{1'b0}}, mag(b)};
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            x_reg   <= x;
            cnt_reg <= STEP_W'(DATA_W - 1);
        end
        else if (busy_reg)
        begin
            p_reg   <= {sum, p_reg[DATA_W-1:1]};
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
        if (fin_reg)
        begin
            v_reg <= v_next;
        end
        if (fin2_reg)
        begin
            if (r_in_range)
            begin
                res_reg <= r[DATA_W-1:0];
            end
            else
            begin
                res_reg <= r[R_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### hw/rtl/tridiagonal_system_solver.sv
// Tridiagonal system solver (Thomas algorithm) on signed Q16.16 words.
// Feed one row per input word: tdata carries sub, main and super diagonal
// and right-hand side, tuser the mode bit (read on the first row only;
// 1 means sub_diag already holds the multiplier and main_diag the pivot),
// tlast marks the last row. Forward elimination runs as each row arrives.
// In mode 0 a row takes one 48-step bit-serial divide, then two 32-step
// serial multiply-subtracts in turn; every row is accepted only once the
// previous one is finished. After the last row the block back-substitutes
// and emits one word per unknown from the last index down to 0; each
// later word needs one read of the row stores, one multiply-subtract and
// one divide. If an earlier pivot fell below pivot_tolerance, the final
// pivot is zero, or more than 64 rows came in, a single word with status
// 1 and last set replaces the solution. pivot_tolerance resets to 1 and
// is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
module tridiagonal_system_solver import tss_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [TOL_W-1:0]    cfg_wr_data,   // pivot_tolerance
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,       // sub_diag, main_diag, super_diag, rhs
    input  logic                s_tuser,       // mode
    input  logic                s_tlast,       // last_row
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,       // row_index, solution, zero fill
    output logic                m_tuser,       // status
    output logic                m_tlast        // last_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_FDIV,
        S_FMS1,
        S_FMS2,
        S_LASTCHK,
        S_BDIV,
        S_EMIT,
        S_RD,
        S_RD2,
        S_BMS
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic              sing_reg, sing_next;
    logic              mode_reg, mode_next;
    logic [TOL_W-1:0]  tol_reg;
    logic [DATA_W-1:0] sub_reg, main_reg, sup_reg, rhs_reg;
    logic              last_reg;
    logic [DATA_W-1:0] prev_piv_reg, prev_piv_next;
    logic [DATA_W-1:0] prev_rhs_reg, prev_rhs_next;
    logic [DATA_W-1:0] prev_sup_reg, prev_sup_next;
    logic [DATA_W-1:0] m_reg, m_next;
    logic [DATA_W-1:0] piv_reg, piv_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] bpiv_reg, bpiv_next;
    logic [ROW_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_idx_reg, out_idx_next;
    logic [DATA_W-1:0] out_sol_reg, out_sol_next;
    logic              out_stat_reg, out_stat_next;
    logic              out_last_reg, out_last_next;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_n, div_d, div_q;
    logic              ms_start, ms_done;
    logic [DATA_W-1:0] ms_x, ms_a, ms_b, ms_res;

    logic              wr_en;
    logic [DATA_W-1:0] wr_piv, wr_rhs;
    logic [DATA_W-1:0] rd_piv, rd_rhs, rd_sup;

    logic              in_acc;
    logic              prev_small;
    logic              out_free;

    assign in_acc     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign prev_small = (prev_piv_reg == '0)
                        || (mag(prev_piv_reg) < {{(DATA_W-TOL_W){1'b0}}, tol_reg});
    assign out_free   = !out_valid_reg || m_tready;

    tss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .done  (div_done),
        .quot  (div_q)
    );

    tss_msub u_msub (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ms_start),
        .x     (ms_x),
        .a     (ms_a),
        .b     (ms_b),
        .done  (ms_done),
        .res   (ms_res)
    );

    // Row stores; each row is written once and read back during the solve.
    tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_piv_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_count_reg[ROW_W-1:0]),
        .wdata (wr_piv),
        .raddr (idx_reg),
        .rdata (rd_piv)
    );

    tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_count_reg[ROW_W-1:0]),
        .wdata (wr_rhs),
        .raddr (idx_reg),
        .rdata (rd_rhs)
    );

    tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_sup_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_count_reg[ROW_W-1:0]),
        .wdata (sup_reg),
        .raddr (idx_reg),
        .rdata (rd_sup)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        sing_next      = sing_reg;
        mode_next      = mode_reg;
        prev_piv_next  = prev_piv_reg;
        prev_rhs_next  = prev_rhs_reg;
        prev_sup_next  = prev_sup_reg;
        m_next         = m_reg;
        piv_next       = piv_reg;
        x_next         = x_reg;
        bpiv_next      = bpiv_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_sol_next   = out_sol_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        div_n          = sub_reg;
        div_d          = prev_piv_reg;
        ms_start       = 1'b0;
        ms_x           = rhs_reg;
        ms_a           = m_reg;
        ms_b           = prev_rhs_reg;
        wr_en          = 1'b0;
        wr_piv         = piv_reg;
        wr_rhs         = ms_res;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (row_count_reg == '0)
                    begin
                        mode_next = s_tuser;
                    end
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (row_count_reg >= CNT_W'(MAX_ROWS))
                begin
                    // Too many rows: nothing is stored.
                    sing_next  = 1'b1;
                    state_next = S_LASTCHK;
                end
                else if (row_count_reg == '0)
                begin
                    wr_en          = 1'b1;
                    wr_piv         = main_reg;
                    wr_rhs         = rhs_reg;
                    prev_piv_next  = main_reg;
                    prev_rhs_next  = rhs_reg;
                    prev_sup_next  = sup_reg;
                    row_count_next = row_count_reg + CNT_W'(1);
                    state_next     = S_LASTCHK;
                end
                else if (sing_reg || prev_small)
                begin
                    // Rows after a rejected pivot are only counted.
                    sing_next      = 1'b1;
                    row_count_next = row_count_reg + CNT_W'(1);
                    state_next     = S_LASTCHK;
                end
                else if (!mode_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_FDIV;
                end
                else
                begin
                    m_next     = sub_reg;
                    piv_next   = main_reg;
                    ms_start   = 1'b1;
                    ms_a       = sub_reg;
                    state_next = S_FMS2;
                end
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    m_next     = div_q;
                    ms_start   = 1'b1;
                    ms_x       = main_reg;
                    ms_a       = div_q;
                    ms_b       = prev_sup_reg;
                    state_next = S_FMS1;
                end
            end
            S_FMS1:
            begin
                if (ms_done)
                begin
                    piv_next   = ms_res;
                    ms_start   = 1'b1;
                    state_next = S_FMS2;
                end
            end
            S_FMS2:
            begin
                if (ms_done)
                begin
                    wr_en          = 1'b1;
                    prev_piv_next  = piv_reg;
                    prev_rhs_next  = ms_res;
                    prev_sup_next  = sup_reg;
                    row_count_next = row_count_reg + CNT_W'(1);
                    state_next     = S_LASTCHK;
                end
            end
            S_LASTCHK:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (sing_reg || prev_piv_reg == '0)
                begin
                    sing_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = prev_rhs_reg;
                    idx_next   = ROW_W'(row_count_reg - CNT_W'(1));
                    state_next = S_BDIV;
                end
            end
            S_BDIV:
            begin
                if (div_done)
                begin
                    x_next     = div_q;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = sing_reg ? '0 : idx_reg;
                    out_sol_next   = sing_reg ? '0 : x_reg;
                    out_stat_next  = sing_reg ? STATUS_SINGULAR : STATUS_OK;
                    out_last_next  = sing_reg || idx_reg == '0;
                    if (sing_reg || idx_reg == '0)
                    begin
                        row_count_next = '0;
                        sing_next      = 1'b0;
                        mode_next      = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ROW_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                bpiv_next  = rd_piv;
                ms_start   = 1'b1;
                ms_x       = rd_rhs;
                ms_a       = rd_sup;
                ms_b       = x_reg;
                state_next = S_BMS;
            end
            S_BMS:
            begin
                if (ms_done)
                begin
                    div_start  = 1'b1;
                    div_n      = ms_res;
                    div_d      = bpiv_reg;
                    state_next = S_BDIV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            sing_reg      <= 1'b0;
            mode_reg      <= 1'b0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            sing_reg      <= sing_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sub_reg  <= s_tdata[DATA_W-1:0];
            main_reg <= s_tdata[2*DATA_W-1:DATA_W];
            sup_reg  <= s_tdata[3*DATA_W-1:2*DATA_W];
            rhs_reg  <= s_tdata[4*DATA_W-1:3*DATA_W];
            last_reg <= s_tlast;
        end
        prev_piv_reg <= prev_piv_next;
        prev_rhs_reg <= prev_rhs_next;
        prev_sup_reg <= prev_sup_next;
        m_reg        <= m_next;
        piv_reg      <= piv_next;
        x_reg        <= x_next;
        bpiv_reg     <= bpiv_next;
        idx_reg      <= idx_next;
        out_idx_reg  <= out_idx_next;
        out_sol_reg  <= out_sol_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-ROW_W-DATA_W){1'b0}}, out_sol_reg, out_idx_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/tss_checker.sv
module tss_checker import tss_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    // A stalled result word stays valid and holds its data and last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // A singular status word is always last, with an all-zero data field.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
        else $error("singular word malformed");

    // The last word of a successful run carries index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[ROW_W-1:0] == '0)
        else $error("last word not at index zero");

    // No row is taken in the cycle right after one was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("row accepted while previous row in work");

endmodule

bind tridiagonal_system_solver tss_checker u_tss_checker (.*);
